/* hdl/pes_pkg.sv */
package pes_pkg;

  localparam int unsigned TIME_W   = 40;
  localparam int unsigned ID_W     = 32;
  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned DAYS_W   = 7;
  localparam int unsigned WD_W     = 3;
  localparam int unsigned SLOT_W   = 4;

  // Most results one tick may produce.
  localparam int unsigned RESULT_LIMIT = 16;
  localparam int unsigned RCNT_W       = 5;

  // Item kinds.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // One input item as it travels through the queue.
  typedef struct packed {
    logic                action;
    logic [SLOT_W-1:0]   slot;
    logic [ID_W-1:0]     entry_id;
    logic [TIME_W-1:0]   first_run;
    logic [PERIOD_W-1:0] repeat_period;
    logic [DAYS_W-1:0]   weekday_mask;
    logic                exact_timing;
    logic                single_shot;
    logic                has_run;
    logic [TIME_W-1:0]   current_time;
    logic [WD_W-1:0]     weekday;
  } pes_item_t;

  // One table entry.
  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [TIME_W-1:0]   tm;
    logic [PERIOD_W-1:0] period;
    logic [DAYS_W-1:0]   days;
    logic                exact;
    logic                once;
    logic                ran;
  } pes_entry_t;

  // One result item.
  typedef struct packed {
    logic [ID_W-1:0]   due_id;
    logic [SLOT_W-1:0] due_slot;
    logic              fired;
    logic [TIME_W-1:0] next_time;
    logic              kept;
  } pes_res_t;

endpackage

/* hdl/periodic_event_scheduler.sv */
// Channel   Ports                          Transfer
// input     start, busy, in_*              start high while busy low
// result    out_valid, out_*               out_valid high for one cycle
//
// A load passes through the queue and from the queue into the table.
// A tick scans the table once per result, runs the remainder unit for each exact
// entry with a period, and ends with a closing scan unless the sixteenth result
// ends it.
// A two-item queue decouples acceptance; busy is high when it is full or in reset.
// Reset is synchronous; all slots read as empty afterwards. The receiver cannot stall.
module periodic_event_scheduler #(
  parameter int unsigned TABLE_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [3:0]  in_slot,
  input  logic [31:0] in_entry_id,
  input  logic [39:0] in_first_run,
  input  logic [31:0] in_repeat_period,
  input  logic [6:0]  in_weekday_mask,
  input  logic        in_exact_timing,
  input  logic        in_single_shot,
  input  logic        in_has_run,
  input  logic [39:0] in_current_time,
  input  logic [2:0]  in_weekday,
  output logic        out_valid,
  output logic [31:0] out_due_id,
  output logic [3:0]  out_due_slot,
  output logic        out_fired,
  output logic [39:0] out_next_time,
  output logic        out_kept,
  output logic        out_last
);
  import pes_pkg::*;

  pes_item_t in_item;
  pes_item_t q_item;
  pes_res_t  res;
  logic      q_valid;
  logic      q_pop;

  // Gather the input fields into one item.
  assign in_item = '{action: in_action, slot: in_slot, entry_id: in_entry_id,
                     first_run: in_first_run, repeat_period: in_repeat_period,
                     weekday_mask: in_weekday_mask, exact_timing: in_exact_timing,
                     single_shot: in_single_shot, has_run: in_has_run,
                     current_time: in_current_time, weekday: in_weekday};

  pes_front #(.TABLE_SLOTS(TABLE_SLOTS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  pes_back #(.TABLE_SLOTS(TABLE_SLOTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_res   (res),
    .out_last  (out_last)
  );

  // Spread the result onto its ports.
  assign out_due_id    = res.due_id;
  assign out_due_slot  = res.due_slot;
  assign out_fired     = res.fired;
  assign out_next_time = res.next_time;
  assign out_kept      = res.kept;

endmodule

/* hdl/pes_front.sv */
module pes_front #(
  parameter int unsigned TABLE_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  pes_pkg::pes_item_t in_item,
  output logic               q_valid,
  output pes_pkg::pes_item_t q_item,
  input  logic               q_pop
);
  import pes_pkg::*;

  pes_item_t  q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       acc;
  logic       keep_item;
  logic       push;

  // The queue is full or the block is in reset.
  assign busy = (cnt_r == 2'd2) || !rst_n;
  assign acc  = start && !busy;

  // Loads into slots beyond the table are dropped here.
  assign keep_item = (in_item.action == ACT_TICK) ||
                     (32'(in_item.slot) < TABLE_SLOTS);
  assign push      = acc && keep_item;

  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = q_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (q_pop && q_valid) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop && q_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

/* hdl/pes_rem.sv */
module pes_rem (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [39:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] rem
);

  logic [39:0] dq_r, dq_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dv_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  // One restoring step per cycle, one quotient bit each.
  assign trial = {rem_r, dq_r[39]};

  always_comb begin
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (go) begin
      dq_nxt  = dividend;
      rem_nxt = '0;
      cnt_nxt = 6'd40;
      run_nxt = 1'b1;
    end else if (run_r) begin
      dq_nxt = {dq_r[38:0], 1'b0};
      if (trial >= {1'b0, dv_r}) begin
        rem_nxt = 32'(trial - {1'b0, dv_r});
      end else begin
        rem_nxt = trial[31:0];
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    if (go) begin
      dv_r <= divisor;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

/* hdl/pes_back.sv */
module pes_back #(
  parameter int unsigned TABLE_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  pes_pkg::pes_item_t q_item,
  output logic               q_pop,
  output logic               out_valid,
  output pes_pkg::pes_res_t  out_res,
  output logic               out_last
);
  import pes_pkg::*;

  localparam int unsigned AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_SLOTS - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_WAIT   = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_UPD    = 3'd5;

  pes_entry_t mem_r [TABLE_SLOTS];
  pes_entry_t rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] wr_addr;
  pes_entry_t    wr_data;

  logic [2:0] state_r, state_nxt;
  logic [TABLE_SLOTS-1:0] valid_r, valid_nxt;
  logic [TABLE_SLOTS-1:0] handled_r, handled_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [WD_W-1:0]   wd_r, wd_nxt;
  logic [AW-1:0]     scan_idx_r, scan_idx_nxt;
  logic              iss_r, iss_nxt;
  logic              ev_v_r, ev_v_nxt;
  logic [AW-1:0]     ev_idx_r, ev_idx_nxt;
  logic              found_r, found_nxt;
  logic [AW-1:0]     best_idx_r, best_idx_nxt;
  logic [TIME_W-1:0] best_tm_r, best_tm_nxt;
  logic [RCNT_W-1:0] rcnt_r, rcnt_nxt;
  logic              pend_r, pend_nxt;
  pes_res_t          res_r, res_nxt;
  logic              fire_r, fire_nxt;
  logic              oval_r, oval_nxt;
  pes_res_t          ores_r, ores_nxt;
  logic              olast_r, olast_nxt;

  logic              cand;
  logic [7:0]        days8;
  logic              fire_c;
  logic              div_go;
  logic              div_done;
  logic [31:0]       div_rem;
  logic [TIME_W:0]   sum_c;
  logic [TIME_W-1:0] new_tm;
  logic              load_ok;

  pes_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (now_r - rd_data_r.tm),
    .divisor  (rd_data_r.period),
    .done     (div_done),
    .rem      (div_rem)
  );

  // Candidate test for the entry whose data just came out of the table.
  assign cand = valid_r[ev_idx_r] && !handled_r[ev_idx_r] && (rd_data_r.tm <= now_r);

  // Weekday gate and run-once check of the picked entry.
  assign days8  = {1'b0, rd_data_r.days};
  assign fire_c = ((rd_data_r.days == '0) || days8[wd_r]) &&
                  !(rd_data_r.once && rd_data_r.ran);

  // New scheduled time, saturated to the time range.
  always_comb begin
    if (rd_data_r.exact) begin
      sum_c = {1'b0, now_r} - {9'b0, div_rem} + {9'b0, rd_data_r.period};
    end else begin
      sum_c = {1'b0, now_r} + {9'b0, rd_data_r.period};
    end
    new_tm = sum_c[TIME_W] ? '1 : sum_c[TIME_W-1:0];
  end

  assign load_ok = !(q_item.single_shot && q_item.has_run);

  // Sequencer for loads and tick scans.
  always_comb begin
    state_nxt    = state_r;
    valid_nxt    = valid_r;
    handled_nxt  = handled_r;
    now_nxt      = now_r;
    wd_nxt       = wd_r;
    scan_idx_nxt = scan_idx_r;
    iss_nxt      = iss_r;
    ev_v_nxt     = 1'b0;
    ev_idx_nxt   = scan_idx_r;
    found_nxt    = found_r;
    best_idx_nxt = best_idx_r;
    best_tm_nxt  = best_tm_r;
    rcnt_nxt     = rcnt_r;
    pend_nxt     = pend_r;
    res_nxt      = res_r;
    fire_nxt     = fire_r;
    oval_nxt     = 1'b0;
    ores_nxt     = ores_r;
    olast_nxt    = olast_r;
    q_pop        = 1'b0;
    rd_addr      = best_idx_r;
    we           = 1'b0;
    wr_addr      = best_idx_r;
    wr_data      = rd_data_r;
    div_go       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.action == ACT_LOAD) begin
            we      = 1'b1;
            wr_addr = AW'(q_item.slot);
            wr_data = '{id: q_item.entry_id, tm: q_item.first_run,
                        period: q_item.repeat_period, days: q_item.weekday_mask,
                        exact: q_item.exact_timing, once: q_item.single_shot,
                        ran: q_item.has_run};
            valid_nxt[AW'(q_item.slot)] = load_ok;
          end else begin
            now_nxt      = q_item.current_time;
            wd_nxt       = q_item.weekday;
            handled_nxt  = '0;
            rcnt_nxt     = '0;
            pend_nxt     = 1'b0;
            scan_idx_nxt = '0;
            iss_nxt      = 1'b1;
            found_nxt    = 1'b0;
            state_nxt    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Issue one read per cycle and compare the previous one.
        rd_addr = scan_idx_r;
        if (iss_r) begin
          ev_v_nxt   = 1'b1;
          ev_idx_nxt = scan_idx_r;
          if (scan_idx_r == LAST_IDX) begin
            iss_nxt = 1'b0;
          end else begin
            scan_idx_nxt = scan_idx_r + AW'(1);
          end
        end
        if (ev_v_r) begin
          if (cand && (!found_r || (rd_data_r.tm < best_tm_r))) begin
            found_nxt    = 1'b1;
            best_idx_nxt = ev_idx_r;
            best_tm_nxt  = rd_data_r.tm;
          end
          if (ev_idx_r == LAST_IDX) begin
            state_nxt = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        // The held result goes out now that we know whether more follow.
        if (pend_r) begin
          oval_nxt  = 1'b1;
          ores_nxt  = res_r;
          olast_nxt = !found_r;
          pend_nxt  = 1'b0;
        end
        if (found_r) begin
          handled_nxt[best_idx_r] = 1'b1;
          state_nxt = ST_WAIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WAIT: begin
        fire_nxt = fire_c;
        if ((rd_data_r.period != '0) && rd_data_r.exact) begin
          div_go    = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_UPD;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        we      = 1'b1;
        wr_data = rd_data_r;
        if (fire_r) begin
          wr_data.ran = 1'b1;
        end
        res_nxt.due_id   = rd_data_r.id;
        res_nxt.due_slot = SLOT_W'(best_idx_r);
        res_nxt.fired    = fire_r;
        if (rd_data_r.period != '0) begin
          wr_data.tm        = new_tm;
          res_nxt.next_time = new_tm;
          res_nxt.kept      = 1'b1;
        end else begin
          wr_data.once         = 1'b1;
          valid_nxt[best_idx_r] = 1'b0;
          res_nxt.next_time    = rd_data_r.tm;
          res_nxt.kept         = 1'b0;
        end
        rcnt_nxt = rcnt_r + RCNT_W'(1);
        if (rcnt_nxt == RCNT_W'(RESULT_LIMIT)) begin
          oval_nxt  = 1'b1;
          ores_nxt  = res_nxt;
          olast_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          pend_nxt     = 1'b1;
          scan_idx_nxt = '0;
          iss_nxt      = 1'b1;
          found_nxt    = 1'b0;
          state_nxt    = ST_SCAN;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
      oval_r  <= 1'b0;
      pend_r  <= 1'b0;
      ev_v_r  <= 1'b0;
      iss_r   <= 1'b0;
      found_r <= 1'b0;
      rcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      oval_r  <= oval_nxt;
      pend_r  <= pend_nxt;
      ev_v_r  <= ev_v_nxt;
      iss_r   <= iss_nxt;
      found_r <= found_nxt;
      rcnt_r  <= rcnt_nxt;
    end
  end

  // Working values.
  always_ff @(posedge clk) begin
    handled_r  <= handled_nxt;
    now_r      <= now_nxt;
    wd_r       <= wd_nxt;
    scan_idx_r <= scan_idx_nxt;
    ev_idx_r   <= ev_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_tm_r  <= best_tm_nxt;
    res_r      <= res_nxt;
    fire_r     <= fire_nxt;
    ores_r     <= ores_nxt;
    olast_r    <= olast_nxt;
  end

  // Entry table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign out_valid = oval_r;
  assign out_res   = ores_r;
  assign out_last  = olast_r;

endmodule

/* hdl/pes_chk.sv */
module pes_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_last
);

  // No transfer can be taken while reset is held.
  a_busy_in_reset: assert property (@(posedge clk) !rst_n |-> busy)
    else $error("busy low during reset");

  // Reset clears the result strobe.
  a_no_out_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe after reset");

  // Results are spaced apart, never in adjacent cycles.
  a_spaced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results in adjacent cycles");

  // The queue is empty when reset is released.
  a_ready_after_reset: assert property (@(posedge clk)
    ($past(!rst_n) && rst_n) |-> !busy)
    else $error("busy right after reset");

  // Out of reset, start, out_valid and the last flag of a result are always known.
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({start, out_valid}) && (!out_valid || !$isunknown(out_last)))
    else $error("unknown handshake or last flag");

endmodule

bind periodic_event_scheduler pes_chk u_pes_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_last  (out_last)
);

/* tb/sv/pes_checker.sv */
`timescale 1ns / 1ps

module pes_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_action,
  input  logic [3:0]  in_slot,
  input  logic [31:0] in_entry_id,
  input  logic [39:0] in_first_run,
  input  logic [31:0] in_repeat_period,
  input  logic [6:0]  in_weekday_mask,
  input  logic        in_exact_timing,
  input  logic        in_single_shot,
  input  logic        in_has_run,
  input  logic [39:0] in_current_time,
  input  logic [2:0]  in_weekday,
  input  logic        out_valid,
  input  logic [31:0] out_due_id,
  input  logic [3:0]  out_due_slot,
  input  logic        out_fired,
  input  logic [39:0] out_next_time,
  input  logic        out_kept,
  input  logic        out_last,
  output int          fail_count,
  output int          pending_count
);
  import pes_pkg::*;

  localparam logic [TIME_W-1:0] TIME_TOP = {TIME_W{1'b1}};

  typedef struct {
    pes_res_t res;
    logic     last;
  } due_t;

  // Shadow copy of the schedule table.
  logic       tbl_valid [16];
  pes_entry_t tbl [16];
  due_t       due_q [$];

  assign pending_count = due_q.size();

  task automatic report(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic logic [TIME_W-1:0] clamp_time(input logic [TIME_W:0] t);
    return t[TIME_W] ? TIME_TOP : t[TIME_W-1:0];
  endfunction

  // Work out the results of one tick and update the shadow table.
  task automatic schedule_tick(input logic [TIME_W-1:0] now, input logic [2:0] wd);
    logic   done [16];
    int     pick;
    int     n;
    logic   fire;
    logic   keep;
    logic [TIME_W-1:0] diff;
    due_t   d;
    n = 0;
    foreach (done[i]) done[i] = 1'b0;
    while (n < RESULT_LIMIT) begin
      pick = -1;
      for (int i = 0; i < 16; i++) begin
        if (tbl_valid[i] && !done[i] && tbl[i].tm <= now)
          if (pick < 0 || tbl[i].tm < tbl[pick].tm) pick = i;
      end
      if (pick < 0) break;
      done[pick] = 1'b1;
      fire = (tbl[pick].days == '0 || (wd <= 3'd6 && tbl[pick].days[wd]))
             && !(tbl[pick].once && tbl[pick].ran);
      if (fire) tbl[pick].ran = 1'b1;
      if (tbl[pick].period != '0) begin
        if (tbl[pick].exact) begin
          diff = now - tbl[pick].tm;
          tbl[pick].tm = clamp_time({1'b0, now - (diff % tbl[pick].period)}
                                    + tbl[pick].period);
        end else begin
          tbl[pick].tm = clamp_time({1'b0, now} + tbl[pick].period);
        end
        keep = 1'b1;
      end else begin
        tbl[pick].once = 1'b1;
        tbl_valid[pick] = 1'b0;
        keep = 1'b0;
      end
      d.res = '{due_id: tbl[pick].id, due_slot: pick[3:0], fired: fire,
                next_time: tbl[pick].tm, kept: keep};
      d.last = 1'b0;
      due_q = {due_q, d};
      n++;
    end
    if (n > 0) due_q[$].last = 1'b1;
  endtask

  initial begin
    fail_count = 0;
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
  end

  // Predict on each accepted input transfer, check each result transfer.
  always @(posedge clk) begin
    due_t d;
    if (rst_n && out_valid) begin
      if (due_q.size() == 0) begin
        report($sformatf("unexpected result id %h slot %0d", out_due_id, out_due_slot));
      end else begin
        d = due_q.pop_front();
        if (out_due_id !== d.res.due_id)
          report($sformatf("due_id %h, want %h", out_due_id, d.res.due_id));
        if (out_due_slot !== d.res.due_slot)
          report($sformatf("due_slot %0d, want %0d", out_due_slot, d.res.due_slot));
        if (out_fired !== d.res.fired)
          report($sformatf("fired %b, want %b", out_fired, d.res.fired));
        if (out_next_time !== d.res.next_time)
          report($sformatf("next_time %h, want %h", out_next_time, d.res.next_time));
        if (out_kept !== d.res.kept)
          report($sformatf("kept %b, want %b", out_kept, d.res.kept));
        if (out_last !== d.last)
          report($sformatf("last %b, want %b", out_last, d.last));
      end
    end
    if (rst_n && start && !busy) begin
      if (in_action == ACT_LOAD) begin
        tbl[in_slot] = '{id: in_entry_id, tm: in_first_run, period: in_repeat_period,
                         days: in_weekday_mask, exact: in_exact_timing,
                         once: in_single_shot, ran: in_has_run};
        tbl_valid[in_slot] = !(in_single_shot && in_has_run);
      end else begin
        schedule_tick(in_current_time, in_weekday);
      end
    end
  end

endmodule

/* tb/sv/tb_periodic_event_scheduler.sv */
`timescale 1ns / 1ps

module tb_periodic_event_scheduler;
  import pes_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_action;
  logic [3:0]  in_slot;
  logic [31:0] in_entry_id;
  logic [39:0] in_first_run;
  logic [31:0] in_repeat_period;
  logic [6:0]  in_weekday_mask;
  logic        in_exact_timing;
  logic        in_single_shot;
  logic        in_has_run;
  logic [39:0] in_current_time;
  logic [2:0]  in_weekday;
  logic        out_valid;
  logic [31:0] out_due_id;
  logic [3:0]  out_due_slot;
  logic        out_fired;
  logic [39:0] out_next_time;
  logic        out_kept;
  logic        out_last;
  int          fail_count;
  int          pending_count;

  // Simulated clock of the schedule, advanced by the ticks.
  logic [39:0] sched_now;
  int          idle_pct;

  periodic_event_scheduler dut (.*);
  pes_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("[periodic_event_scheduler] ERROR");
    $finish;
  end

  // Random gap, then hold one item until its transfer.
  task automatic send(input logic act, input logic [3:0] sl, input logic [31:0] id,
                      input logic [39:0] t0, input logic [31:0] per, input logic [6:0] days,
                      input logic ex, input logic once, input logic ran,
                      input logic [39:0] now, input logic [2:0] wd);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_action <= act;  in_slot <= sl;  in_entry_id <= id;  in_first_run <= t0;
    in_repeat_period <= per;  in_weekday_mask <= days;  in_exact_timing <= ex;
    in_single_shot <= once;  in_has_run <= ran;  in_current_time <= now;
    in_weekday <= wd;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic load(input logic [3:0] sl, input logic [31:0] id, input logic [39:0] t0,
                      input logic [31:0] per, input logic [6:0] days, input logic ex,
                      input logic once, input logic ran);
    send(ACT_LOAD, sl, id, t0, per, days, ex, once, ran, 40'($urandom()),
         3'($urandom()));
  endtask

  task automatic tick(input logic [39:0] now, input logic [2:0] wd);
    send(ACT_TICK, 4'($urandom()), $urandom(), 40'({$urandom(), $urandom()}),
         $urandom(), 7'($urandom()), 1'($urandom()), 1'($urandom()), 1'($urandom()),
         now, wd);
  endtask

  // Mostly loads near the schedule clock with small periods, then ticks forward.
  task automatic random_item();
    logic [31:0] per;
    logic [39:0] t0;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      per = ($urandom_range(9) == 0) ? 32'd0 :
            ($urandom_range(19) == 0) ? $urandom() : $urandom_range(1, 200);
      t0 = ($urandom_range(29) == 0) ? 40'({$urandom(), $urandom()}) :
           sched_now + $urandom_range(0, 300) - 40'd100;
      load(4'($urandom()), $urandom(), t0, per,
           ($urandom_range(2) == 0) ? 7'd0 : 7'($urandom()),
           1'($urandom()), $urandom_range(3) == 0, $urandom_range(3) == 0);
    end else begin
      if ($urandom_range(39) == 0) sched_now = 40'({$urandom(), $urandom()});
      else sched_now = sched_now + $urandom_range(0, 250);
      tick(sched_now, 3'($urandom_range(7)));
    end
  endtask

  initial begin
    start = 1'b0;  in_action = ACT_LOAD;  in_slot = '0;  in_entry_id = '0;
    in_first_run = '0;  in_repeat_period = '0;  in_weekday_mask = '0;
    in_exact_timing = 1'b0;  in_single_shot = 1'b0;  in_has_run = 1'b0;
    in_current_time = '0;  in_weekday = '0;
    sched_now = 40'd1000;
    idle_pct = 25;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty tick, field extremes, zero period, run-once, saturation.
    tick('0, 3'd0);
    load(4'd0, 32'hFFFF_FFFF, 40'd0, 32'd0, 7'd0, 1'b0, 1'b0, 1'b0);
    load(4'd15, 32'd0, 40'd0, 32'hFFFF_FFFF, 7'h7F, 1'b1, 1'b0, 1'b0);
    load(4'd1, 32'h1234_5678, 40'd5, 32'd7, 7'b000_0010, 1'b0, 1'b0, 1'b0);
    load(4'd2, 32'hA5A5_5A5A, 40'd5, 32'd3, 7'b100_0000, 1'b1, 1'b1, 1'b0);
    load(4'd3, 32'h0000_0003, 40'd2, 32'd0, 7'd0, 1'b0, 1'b1, 1'b1);
    load(4'd4, 32'h0000_0004, 40'd1, 32'd4, 7'd0, 1'b0, 1'b1, 1'b1);
    load(4'd5, 32'h0000_0005, 40'hFF_FFFF_FFF0, 32'd100, 7'd0, 1'b0, 1'b0, 1'b0);
    load(4'd6, 32'h0000_0006, 40'hFF_FFFF_FFF0, 32'd100, 7'd0, 1'b1, 1'b0, 1'b0);
    tick(40'd10, 3'd7);
    tick(40'd20, 3'd1);
    tick(40'd26, 3'd6);
    tick(40'hFF_FFFF_FFFF, 3'd0);
    tick(40'hFF_FFFF_FFFF, 3'd3);
    // Sixteen due entries at once fill one tick.
    for (int i = 0; i < 16; i++)
      load(i[3:0], 32'(i + 100), 40'd50, 32'd1, 7'd0, 1'b0, 1'b0, 1'b0);
    tick(40'd60, 3'd2);

    // Hold off until every expected result has come.
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);

    for (int i = 0; i < 240; i++) begin
      if (i == 80) idle_pct = 52;
      if (i == 160) idle_pct = 0;
      random_item();
    end
    start <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    if (fail_count == 0) begin
      $display("[periodic_event_scheduler] OK");
    end else begin
      $display("[periodic_event_scheduler] ERROR");
    end
    $finish;
  end

endmodule
